[hw/rtl/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // Decoded code point width (up to 21 bits after four bytes)
    localparam int unsigned CP_W       = 21;
    localparam int unsigned UNIT_W     = 16;

    // Queue between decoder and unit emitter
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_1    = 3'd1;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // Code point limits
    localparam logic [CP_W-1:0] MIN_LEN2   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_LEN3   = 21'h000800;
    localparam logic [CP_W-1:0] MIN_LEN4   = 21'h010000;
    localparam logic [CP_W-1:0] SURR_FIRST = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_LAST  = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] SUPP_BASE  = 21'h010000;

    // Surrogate prefixes
    localparam logic [5:0] HI_SURR_PREFIX = 6'b110110;  // 0xD800
    localparam logic [5:0] LO_SURR_PREFIX = 6'b110111;  // 0xDC00

    // One decoded event from the front end
    typedef struct packed {
        logic            is_err;  // string failed: emit the single error result
        logic [CP_W-1:0] point;   // validated code point
        logic            eos;     // event caused by the final byte
    } t_unit_req;

endpackage

[hw/rtl/u8u16_front.sv]
// ----------------------------------------------------------------------------
// u8u16_front
// Byte decoder: collects lead and continuation bytes, checks the finished
// code point and pushes one event per completed point or failed string.
// ----------------------------------------------------------------------------
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  logic [7:0] i_data_byte,
    input  logic      i_end_of_string,
    output logic      o_push,
    output t_unit_req o_req
);

    logic [CP_W-1:0] r_partial, n_partial;
    logic [1:0]      r_remaining, n_remaining;
    logic [2:0]      r_seq_len, n_seq_len;
    logic            r_failed, n_failed;

    logic            complete;
    logic            fail;
    logic            bad_point;
    logic [CP_W-1:0] cp_done;
    logic [CP_W-1:0] cp_next;
    logic [2:0]      len_done;

    // Decode one byte and classify the outcome
    always_comb begin
        n_partial   = r_partial;
        n_remaining = r_remaining;
        n_seq_len   = r_seq_len;
        n_failed    = r_failed;
        o_push      = 1'b0;
        o_req       = '{is_err: 1'b0, point: '0, eos: i_end_of_string};
        complete    = 1'b0;
        fail        = 1'b0;
        bad_point   = 1'b0;
        cp_done     = '0;
        len_done    = r_seq_len;
        cp_next     = {r_partial[CP_W-7:0], i_data_byte[5:0]};

        if (i_accept) begin
            if (r_failed) begin
                // drop bytes until the end mark
                if (i_end_of_string) begin
                    o_push       = 1'b1;
                    o_req.is_err = 1'b1;
                    n_failed     = 1'b0;
                end
            end else if (r_remaining == 2'd0) begin
                if (i_data_byte inside {[8'h00:8'h7F]}) begin
                    complete = 1'b1;
                    cp_done  = {{(CP_W-8){1'b0}}, i_data_byte};
                    len_done = LEN_1;
                end else if (i_data_byte inside {[8'hC0:8'hDF]}) begin
                    n_partial   = {{(CP_W-5){1'b0}}, i_data_byte[4:0]};
                    n_remaining = 2'd1;
                    n_seq_len   = LEN_2;
                    fail        = i_end_of_string;
                end else if (i_data_byte inside {[8'hE0:8'hEF]}) begin
                    n_partial   = {{(CP_W-4){1'b0}}, i_data_byte[3:0]};
                    n_remaining = 2'd2;
                    n_seq_len   = LEN_3;
                    fail        = i_end_of_string;
                end else if (i_data_byte inside {[8'hF0:8'hF7]}) begin
                    n_partial   = {{(CP_W-3){1'b0}}, i_data_byte[2:0]};
                    n_remaining = 2'd3;
                    n_seq_len   = LEN_4;
                    fail        = i_end_of_string;
                end else begin
                    fail = 1'b1;  // stray continuation or 0xF8 and up
                end
            end else begin
                if (i_data_byte[7:6] != 2'b10) begin
                    fail = 1'b1;
                end else begin
                    n_partial   = cp_next;
                    n_remaining = r_remaining - 2'd1;
                    if (r_remaining == 2'd1) begin
                        complete = 1'b1;
                        cp_done  = cp_next;
                    end else begin
                        fail = i_end_of_string;  // truncated
                    end
                end
            end

            // check a finished code point
            if (complete) begin
                bad_point = ((len_done == LEN_2) && (cp_done < MIN_LEN2)) ||
                            ((len_done == LEN_3) && (cp_done < MIN_LEN3)) ||
                            ((len_done == LEN_4) && (cp_done < MIN_LEN4)) ||
                            ((cp_done >= SURR_FIRST) && (cp_done <= SURR_LAST)) ||
                            (cp_done > CP_MAX);
                if (bad_point) begin
                    fail = 1'b1;
                end else begin
                    o_push      = 1'b1;
                    o_req.point = cp_done;
                    n_partial   = '0;
                    n_remaining = 2'd0;
                    n_seq_len   = LEN_NONE;
                end
            end

            // record an error; report it now at the end mark
            if (fail) begin
                n_partial   = '0;
                n_remaining = 2'd0;
                n_seq_len   = LEN_NONE;
                if (i_end_of_string) begin
                    o_push       = 1'b1;
                    o_req.is_err = 1'b1;
                    o_req.point  = '0;
                    n_failed     = 1'b0;
                end else begin
                    n_failed = 1'b1;
                end
            end
        end
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_remaining <= 2'd0;
            r_seq_len   <= LEN_NONE;
            r_failed    <= 1'b0;
        end else begin
            r_partial   <= n_partial;
            r_remaining <= n_remaining;
            r_seq_len   <= n_seq_len;
            r_failed    <= n_failed;
        end
    end

endmodule

[hw/rtl/u8u16_queue.sv]
// ----------------------------------------------------------------------------
// u8u16_queue
// Short FIFO of decoded events between the decoder and the unit emitter.
// The head entry is visible without a read request.
// ----------------------------------------------------------------------------
module u8u16_queue
    import u8u16_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_unit_req i_push_req,
    input  logic      i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_unit_req o_head
);

    t_unit_req             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QUEUE_DEPTH[QUEUE_AW:0]);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/u8u16_back.sv]
// ----------------------------------------------------------------------------
// u8u16_back
// Unit emitter: turns each queued event into one UTF-16 unit, a surrogate
// pair over two transfers, or the error result, through an output register.
// ----------------------------------------------------------------------------
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_unit_req         i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [UNIT_W-1:0] o_code_unit,
    output logic              o_error,
    output logic              o_string_end
);

    logic              r_valid, n_valid;
    logic              r_phase, n_phase;     // 1: high surrogate already sent
    logic [UNIT_W-1:0] r_unit, n_unit;
    logic              r_err, n_err;
    logic              r_end, n_end;

    logic              load;
    logic              is_pair;
    logic [CP_W-1:0]   supp_off;

    assign load     = !r_valid || !i_out_stall;
    assign is_pair  = (i_head.point[CP_W-1:UNIT_W] != '0);
    assign supp_off = i_head.point - SUPP_BASE;

    // Select the next unit from the head event
    always_comb begin
        n_valid = r_valid;
        n_phase = r_phase;
        n_unit  = r_unit;
        n_err   = r_err;
        n_end   = r_end;
        o_pop   = 1'b0;

        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                if (i_head.is_err) begin
                    n_unit = '0;
                    n_err  = 1'b1;
                    n_end  = 1'b1;
                    o_pop  = 1'b1;
                end else if (is_pair && !r_phase) begin
                    n_unit  = {HI_SURR_PREFIX, supp_off[19:10]};
                    n_err   = 1'b0;
                    n_end   = 1'b0;
                    n_phase = 1'b1;
                end else if (is_pair) begin
                    n_unit  = {LO_SURR_PREFIX, supp_off[9:0]};
                    n_err   = 1'b0;
                    n_end   = i_head.eos;
                    n_phase = 1'b0;
                    o_pop   = 1'b1;
                end else begin
                    n_unit = i_head.point[UNIT_W-1:0];
                    n_err  = 1'b0;
                    n_end  = i_head.eos;
                    o_pop  = 1'b1;
                end
            end
        end
    end

    // Output register and pair phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
        r_unit <= n_unit;
        r_err  <= n_err;
        r_end  <= n_end;
    end

    assign o_out_valid  = r_valid;
    assign o_code_unit  = r_unit;
    assign o_error      = r_err;
    assign o_string_end = r_end;

endmodule

[hw/rtl/utf8_to_utf16_transcoder_unit.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit
// Path: each result goes through the event queue and the output register.
// Throughput: one byte per cycle in unless the queue is full; one result
// per cycle out unless stalled; the 4-entry queue absorbs surrogate pairs.
// Reset: synchronous active-low i_rst_n clears decoder, queue and o_out_valid.
// Top level: decoder, event queue and unit emitter.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit
    import u8u16_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_string,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [UNIT_W-1:0] o_code_unit,
    output logic              o_error,
    output logic              o_string_end
);

    logic      accept;
    logic      push;
    t_unit_req push_req;
    logic      pop;
    logic      q_full;
    logic      q_empty;
    t_unit_req q_head;

    // Input transfer when the queue has room
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    u8u16_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .o_push          (push),
        .o_req           (push_req)
    );

    u8u16_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_req (push_req),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_empty    (q_empty),
        .o_head     (q_head)
    );

    u8u16_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_head       (q_head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_code_unit  (o_code_unit),
        .o_error      (o_error),
        .o_string_end (o_string_end)
    );

endmodule

[sim/utf8_to_utf16_transcoder_unit_tb.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit_tb
// Drives UTF-8 strings into the transcoder one byte per transfer. A local
// decoder predicts each UTF-16 unit and the error results, and every output
// transfer is compared field by field with the oldest prediction. The run
// has a directed part, a random part under random idling on both sides, and
// a back-to-back tail.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit_tb
    import u8u16_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // One predicted UTF-16 result
    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              err;
        logic              eos_flag;
    } t_utf16_result;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic              o_in_stall;
    logic [7:0]        i_data_byte     = 8'h00;
    logic              i_end_of_string = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall     = 1'b0;
    logic [UNIT_W-1:0] o_code_unit;
    logic              o_error;
    logic              o_string_end;

    // Predictor state
    logic [CP_W-1:0]   cp_acc;
    logic [1:0]        cont_left;
    logic [2:0]        seq_len;
    logic              str_bad;

    t_utf16_result     expected_units[$];
    t_utf16_result     next_unit;
    logic [7:0]        str_bytes[$];

    bit                idle_en     = 1'b1;
    int                stall_left  = 0;
    int                byte_count  = 0;
    int                err_count   = 0;

    utf8_to_utf16_transcoder_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_code_unit     (o_code_unit),
        .o_error         (o_error),
        .o_string_end    (o_string_end)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic void clear_decoder();
        cp_acc    = '0;
        cont_left = '0;
        seq_len   = LEN_NONE;
        str_bad   = 1'b0;
    endfunction

    // Invalid string: error result now if this is the final byte, else drop
    function automatic void reject_string(input bit eos);
        clear_decoder();
        if (eos) begin
            expected_units.push_back(t_utf16_result'{unit: '0, err: 1'b1, eos_flag: 1'b1});
        end else begin
            str_bad = 1'b1;
        end
    endfunction

    function automatic void complete_point(input logic [CP_W-1:0] cp, input bit eos);
        logic [CP_W-1:0] v;
        if ((seq_len == LEN_2 && cp < MIN_LEN2) || (seq_len == LEN_3 && cp < MIN_LEN3) ||
            (seq_len == LEN_4 && cp < MIN_LEN4) ||
            (cp >= SURR_FIRST && cp <= SURR_LAST) || cp > CP_MAX) begin
            reject_string(eos);
            return;
        end
        clear_decoder();
        if (cp >= SUPP_BASE) begin
            v = cp - SUPP_BASE;
            expected_units.push_back(t_utf16_result'{unit: {HI_SURR_PREFIX, v[19:10]},
                                                     err: 1'b0, eos_flag: 1'b0});
            expected_units.push_back(t_utf16_result'{unit: {LO_SURR_PREFIX, v[9:0]},
                                                     err: 1'b0, eos_flag: eos});
        end else begin
            expected_units.push_back(t_utf16_result'{unit: cp[15:0], err: 1'b0, eos_flag: eos});
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input bit eos);
        // failed string: swallow bytes up to the end mark
        if (str_bad) begin
            if (eos) begin
                clear_decoder();
                expected_units.push_back(t_utf16_result'{unit: '0, err: 1'b1, eos_flag: 1'b1});
            end
            return;
        end
        // lead byte
        if (cont_left == 2'd0) begin
            if (b[7] == 1'b0) begin
                seq_len = LEN_1;
                complete_point({13'b0, b}, eos);
                return;
            end else if (b[7:5] == 3'b110) begin
                cp_acc    = {16'b0, b[4:0]};
                cont_left = 2'd1;
                seq_len   = LEN_2;
            end else if (b[7:4] == 4'b1110) begin
                cp_acc    = {17'b0, b[3:0]};
                cont_left = 2'd2;
                seq_len   = LEN_3;
            end else if (b[7:3] == 5'b11110) begin
                cp_acc    = {18'b0, b[2:0]};
                cont_left = 2'd3;
                seq_len   = LEN_4;
            end else begin
                reject_string(eos);
                return;
            end
            if (eos) reject_string(eos);   // string ends inside the sequence
            return;
        end
        // continuation byte
        if (b[7:6] != 2'b10) begin
            reject_string(eos);
            return;
        end
        cp_acc    = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
            complete_point(cp_acc, eos);
        end else if (eos) begin
            reject_string(eos);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit eos);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_string <= eos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_byte(b, eos);
        byte_count++;
    endtask

    task automatic send_string();
        foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    task automatic push_point(input logic [CP_W-1:0] cp);
        if (cp < MIN_LEN2) begin
            str_bytes.push_back(cp[7:0]);
        end else if (cp < MIN_LEN3) begin
            str_bytes.push_back({3'b110, cp[10:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < MIN_LEN4) begin
            str_bytes.push_back({4'b1110, cp[15:12]});
            str_bytes.push_back({2'b10, cp[11:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            str_bytes.push_back({5'b11110, cp[20:18]});
            str_bytes.push_back({2'b10, cp[17:12]});
            str_bytes.push_back({2'b10, cp[11:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    function automatic logic [CP_W-1:0] random_point();
        logic [CP_W-1:0] cp;
        case ($urandom_range(0, 3))
            0: cp = CP_W'($urandom_range(0, 'h7F));
            1: cp = CP_W'($urandom_range('h80, 'h7FF));
            2: begin
                cp = CP_W'($urandom_range('h800, 'hFFFF));
                if (cp >= SURR_FIRST && cp <= SURR_LAST) cp = cp - CP_W'('h1000);
            end
            default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    // Overlong, surrogate and out-of-range sequences
    task automatic push_malformed();
        case ($urandom_range(0, 5))
            0: begin
                str_bytes.push_back(8'hC0 | 8'($urandom_range(0, 1)));
                str_bytes.push_back(cont_byte());
            end
            1: begin
                str_bytes.push_back(8'hE0);
                str_bytes.push_back(8'($urandom_range('h80, 'h9F)));
                str_bytes.push_back(cont_byte());
            end
            2: begin
                str_bytes.push_back(8'hF0);
                str_bytes.push_back(8'($urandom_range('h80, 'h8F)));
                str_bytes.push_back(cont_byte());
                str_bytes.push_back(cont_byte());
            end
            3: begin
                str_bytes.push_back(8'hED);
                str_bytes.push_back(8'($urandom_range('hA0, 'hBF)));
                str_bytes.push_back(cont_byte());
            end
            4: begin
                str_bytes.push_back(8'hF4);
                str_bytes.push_back(8'($urandom_range('h90, 'hBF)));
                str_bytes.push_back(cont_byte());
                str_bytes.push_back(cont_byte());
            end
            default: begin
                str_bytes.push_back(8'($urandom_range('hF5, 'hF7)));
                repeat (3) str_bytes.push_back(cont_byte());
            end
        endcase
    endtask

    // Mostly well-formed strings, with noise, truncation and bad forms mixed in
    task automatic send_random_string();
        int n;
        int idx;
        logic [7:0] lead;
        str_bytes.delete();
        n = $urandom_range(1, 6);
        repeat (n) push_point(random_point());
        case ($urandom_range(0, 9))
            0: begin
                str_bytes.delete();
                repeat ($urandom_range(1, 6)) str_bytes.push_back(8'($urandom_range(0, 255)));
            end
            1: begin
                lead = 8'($urandom_range('hC2, 'hF4));
                str_bytes.push_back(lead);
                if (lead >= 8'hF0) repeat ($urandom_range(0, 2)) str_bytes.push_back(cont_byte());
                else if (lead >= 8'hE0) repeat ($urandom_range(0, 1)) str_bytes.push_back(cont_byte());
            end
            2: begin
                idx = $urandom_range(0, str_bytes.size() - 1);
                str_bytes[idx] = 8'($urandom_range(0, 255));
            end
            3: begin
                push_malformed();
                repeat ($urandom_range(0, 2)) push_point(random_point());
            end
            default: ;
        endcase
        send_string();
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall bursts and result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 7);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_units.size() == 0) begin
                report_mismatch($sformatf("unexpected result unit=%h err=%b end=%b",
                                          o_code_unit, o_error, o_string_end));
            end else begin
                next_unit = expected_units.pop_front();
                if (o_code_unit !== next_unit.unit || o_error !== next_unit.err ||
                    o_string_end !== next_unit.eos_flag)
                    report_mismatch($sformatf("unit=%h/%h err=%b/%b end=%b/%b (got/exp)",
                                              o_code_unit, next_unit.unit, o_error,
                                              next_unit.err, o_string_end,
                                              next_unit.eos_flag));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // extremes of each length, max supplementary point ends the string
        str_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                      8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        // overlong lead C0, error on the final byte
        str_bytes = '{8'hC0, 8'h80};
        send_string();
        // encoded surrogate
        str_bytes = '{8'hED, 8'hA0, 8'h80};
        send_string();
        // lead F5, above the top code point
        str_bytes = '{8'hF5, 8'h80, 8'h80, 8'h80};
        send_string();
        // stray continuation as the only byte
        str_bytes = '{8'h80};
        send_string();
        // bad lead before the end, later bytes dropped
        str_bytes = '{8'hFF, 8'h41};
        send_string();
        // string ends inside a sequence
        str_bytes = '{8'hE2, 8'h82};
        send_string();
        // bad continuation consumed with the end mark
        str_bytes = '{8'hC3, 8'h41};
        send_string();
    endtask

    task automatic test_random_strings();
        while (byte_count < 1500) send_random_string();
    endtask

    task automatic test_back_to_back();
        idle_en = 1'b0;
        while (byte_count < 1730) send_random_string();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        clear_decoder();

        test_directed();
        test_random_strings();
        test_back_to_back();

        i_in_valid <= 1'b0;
        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
